// ----- design/pmx_pkg.sv -----
package pmx_pkg;

	localparam int MAX_CITIES = 64;
	localparam int CITY_W     = $clog2(MAX_CITIES);
	localparam int CNT_W      = CITY_W + 1;
	localparam int STEP_W     = 3;

	typedef logic [CITY_W-1:0] city_t;
	typedef logic [CNT_W-1:0]  count_t;
	typedef logic [STEP_W-1:0] step_t;

	// jump conditions of the microprogram
	typedef enum logic [2:0] {
		C_NEVER,
		C_ALWAYS,
		C_LOAD_MORE,
		C_IN_SEG,
		C_CHASE_DONE,
		C_OUT_BUSY,
		C_MORE_POS
	} cond_t;

	// program steps
	localparam step_t S_LOAD   = 3'd0;
	localparam step_t S_RD_POS = 3'd1;
	localparam step_t S_CHK    = 3'd2;
	localparam step_t S_HOP    = 3'd3;
	localparam step_t S_HOP_W  = 3'd4;
	localparam step_t S_OUT    = 3'd5;
	localparam step_t S_NEXT   = 3'd6;
	localparam step_t S_RET    = 3'd7;

	// one control word
	typedef struct packed {
		logic  take_in;
		logic  rd_pos;
		logic  chk;
		logic  hop;
		logic  hop_w;
		logic  emit;
		logic  advance;
		cond_t cond;
		step_t target;
	} uword_t;

	// datapath status seen by the sequencer
	typedef struct packed {
		logic load_more;
		logic in_seg;
		logic chase_done;
		logic out_busy;
		logic more_pos;
	} cond_flags_t;

	// microprogram ROM
	function automatic uword_t ucode(step_t s);
		uword_t w;
		w = '0;
		w.cond = C_NEVER;
		w.target = S_LOAD;
		case (s)
			S_LOAD: begin
				w.take_in = 1'b1;
				w.cond    = C_LOAD_MORE;
				w.target  = S_LOAD;
			end
			S_RD_POS: begin
				w.rd_pos = 1'b1;
			end
			S_CHK: begin
				w.chk    = 1'b1;
				w.cond   = C_IN_SEG;
				w.target = S_OUT;
			end
			S_HOP: begin
				w.hop    = 1'b1;
				w.cond   = C_CHASE_DONE;
				w.target = S_OUT;
			end
			S_HOP_W: begin
				w.hop_w  = 1'b1;
				w.cond   = C_ALWAYS;
				w.target = S_HOP;
			end
			S_OUT: begin
				w.emit   = 1'b1;
				w.cond   = C_OUT_BUSY;
				w.target = S_OUT;
			end
			S_NEXT: begin
				w.advance = 1'b1;
				w.cond    = C_MORE_POS;
				w.target  = S_RD_POS;
			end
			S_RET: begin
				w.cond   = C_ALWAYS;
				w.target = S_LOAD;
			end
			default: begin
				w.cond   = C_ALWAYS;
				w.target = S_LOAD;
			end
		endcase
		return w;
	endfunction

endpackage

// ----- design/partially_mapped_crossover_top.sv -----
// PMX crossover of two city permutations. Feed one item per position, in
// position order from 0; the cut bounds are taken from the first item of a
// set, clamped to count - 1 and put in order. Loading takes one item per
// cycle. Once city_count items are in, input stalls and the child is sent
// in position order, last position marked. Emission is run by a small
// microprogram over single-port store memories with registered reads: a
// position is read and checked against the segment, one outside it then
// follows the map (at most 64 hops), and a closing step ends the set. The
// map marks are cleared in the cycle the first item of a set is taken, so
// there is no clearing pass after reset. city_count may only be written
// while the block is idle; a value below 2 acts as 2, above 64 as 64.
module partially_mapped_crossover_top (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  pmx_pkg::count_t      cfg_city_count,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  pmx_pkg::city_t       first_parent_city,
	input  pmx_pkg::city_t       second_parent_city,
	input  pmx_pkg::city_t       cut_start,
	input  pmx_pkg::city_t       cut_end,
	output logic                 out_valid,
	input  logic                 out_stall,
	output pmx_pkg::city_t       child_city,
	output logic                 last_child
);
	import pmx_pkg::*;

	uword_t      uw;
	cond_flags_t flags;

	count_t city_count_q;
	count_t n_eff;
	city_t  n_m1;

	count_t load_pos_q;
	city_t  seg_lo_q, seg_hi_q;
	city_t  cut_a, cut_b, lo_cur, hi_cur;
	logic   first_item, in_fire, last_in, load_in_seg;
	logic [MAX_CITIES-1:0] map_valid_q;
	logic [MAX_CITIES-1:0] map_set;

	// stores: position store holds both parents, map store is keyed by city
	logic [2*CITY_W-1:0] pos_mem [MAX_CITIES];
	city_t               map_mem [MAX_CITIES];
	logic [2*CITY_W-1:0] pos_rd_q;
	city_t               map_rd_q;

	city_t  idx_q, city_q;
	count_t hops_q;
	city_t  rd_p1, rd_p2;
	logic   emit_in_seg, out_free;

	logic   out_valid_q, last_q;
	city_t  child_q;

	pmx_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.flags  (flags),
		.uw     (uw)
	);

	// configuration register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			city_count_q <= count_t'(MAX_CITIES);
		end else if (cfg_valid && cfg_ready) begin
			city_count_q <= cfg_city_count;
		end
	end

	// effective count, clamped to 2..MAX_CITIES
	always_comb begin
		if (city_count_q < count_t'(2))
			n_eff = count_t'(2);
		else if (city_count_q > count_t'(MAX_CITIES))
			n_eff = count_t'(MAX_CITIES);
		else
			n_eff = city_count_q;
	end
	assign n_m1 = city_t'(n_eff - 1'b1);

	// cut bounds: saturate then order
	always_comb begin
		cut_a = (cut_start > n_m1) ? n_m1 : cut_start;
		cut_b = (cut_end > n_m1) ? n_m1 : cut_end;
		first_item = (load_pos_q == '0);
		if (first_item) begin
			lo_cur = (cut_a > cut_b) ? cut_b : cut_a;
			hi_cur = (cut_a > cut_b) ? cut_a : cut_b;
		end else begin
			lo_cur = seg_lo_q;
			hi_cur = seg_hi_q;
		end
	end

	assign in_stall    = !uw.take_in;
	assign in_fire     = in_valid && !in_stall;
	assign last_in     = (count_t'(load_pos_q + 1'b1) >= n_eff);
	assign load_in_seg = (load_pos_q[CITY_W-1:0] >= lo_cur) &&
	                     (load_pos_q[CITY_W-1:0] <= hi_cur);

	// mark for the segment city of this transfer
	assign map_set = load_in_seg ?
	                 ({{(MAX_CITIES-1){1'b0}}, 1'b1} << second_parent_city) : '0;

	// load control; map marks restart on the first item of a set
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_pos_q  <= '0;
			seg_lo_q    <= '0;
			seg_hi_q    <= '0;
			map_valid_q <= '0;
		end else if (in_fire) begin
			load_pos_q  <= last_in ? '0 : count_t'(load_pos_q + 1'b1);
			seg_lo_q    <= lo_cur;
			seg_hi_q    <= hi_cur;
			map_valid_q <= (first_item ? '0 : map_valid_q) | map_set;
		end
	end

	// position store
	always_ff @(posedge clk) begin
		if (in_fire) begin
			pos_mem[load_pos_q[CITY_W-1:0]] <= {first_parent_city, second_parent_city};
		end
		if (uw.rd_pos) begin
			pos_rd_q <= pos_mem[idx_q];
		end
	end

	// map store: second parent city -> first parent city
	always_ff @(posedge clk) begin
		if (in_fire && load_in_seg) begin
			map_mem[second_parent_city] <= first_parent_city;
		end
		if (uw.hop && !flags.chase_done) begin
			map_rd_q <= map_mem[city_q];
		end
	end

	assign rd_p1       = pos_rd_q[2*CITY_W-1:CITY_W];
	assign rd_p2       = pos_rd_q[CITY_W-1:0];
	assign emit_in_seg = (idx_q >= seg_lo_q) && (idx_q <= seg_hi_q);
	assign out_free    = !out_valid_q || !out_stall;

	// status for the sequencer
	always_comb begin
		flags.load_more  = !(in_fire && last_in);
		flags.in_seg     = emit_in_seg;
		flags.chase_done = !map_valid_q[city_q] || (hops_q == count_t'(MAX_CITIES));
		flags.out_busy   = !out_free;
		flags.more_pos   = (idx_q != n_m1);
	end

	// emission datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (uw.advance) begin
			idx_q <= flags.more_pos ? city_t'(idx_q + 1'b1) : '0;
		end
	end

	always_ff @(posedge clk) begin
		if (uw.chk) begin
			city_q <= emit_in_seg ? rd_p2 : rd_p1;
			hops_q <= '0;
		end else if (uw.hop && !flags.chase_done) begin
			hops_q <= count_t'(hops_q + 1'b1);
		end else if (uw.hop_w) begin
			city_q <= map_rd_q;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (uw.emit && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (uw.emit && out_free) begin
			child_q <= city_q;
			last_q  <= (idx_q == n_m1);
		end
	end

	assign out_valid  = out_valid_q;
	assign child_city = child_q;
	assign last_child = last_q;

endmodule

// ----- design/pmx_seq.sv -----
module pmx_seq (
	input  logic                clk,
	input  logic                arst_n,
	input  pmx_pkg::cond_flags_t flags,
	output pmx_pkg::uword_t     uw
);
	import pmx_pkg::*;

	step_t step_q;
	logic  jump;

	// control word of the current step
	assign uw = ucode(step_q);

	// condition select
	always_comb begin
		case (uw.cond)
			C_NEVER:      jump = 1'b0;
			C_ALWAYS:     jump = 1'b1;
			C_LOAD_MORE:  jump = flags.load_more;
			C_IN_SEG:     jump = flags.in_seg;
			C_CHASE_DONE: jump = flags.chase_done;
			C_OUT_BUSY:   jump = flags.out_busy;
			C_MORE_POS:   jump = flags.more_pos;
			default:      jump = 1'b1;
		endcase
	end

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= S_LOAD;
		end else begin
			step_q <= jump ? uw.target : step_t'(step_q + 1'b1);
		end
	end

endmodule

// ----- design/pmx_chk.sv -----
module pmx_chk (
	input logic           clk,
	input logic           arst_n,
	input logic           in_stall,
	input logic           out_valid,
	input logic           out_stall,
	input pmx_pkg::city_t child_city,
	input logic           last_child
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(child_city) && $stable(last_child))
		else $error("stalled result changed");

	// no result appears while the block is taking input
	a_no_emit_in_load: assert property (@(posedge clk) disable iff (!arst_n)
		!in_stall && !out_valid |=> !out_valid)
		else $error("result appeared during load");

	// the marked last result closes the child: nothing follows at once
	a_last_closes: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && last_child |=> !out_valid)
		else $error("result followed the last position");

endmodule

bind partially_mapped_crossover_top pmx_chk u_pmx_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_stall   (in_stall),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.child_city (child_city),
	.last_child (last_child)
);

// ----- verif/partially_mapped_crossover_top_tb.sv -----
module partially_mapped_crossover_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import pmx_pkg::*;

	localparam int unsigned ITEM_GOAL = 340;
	localparam int unsigned CALM_FROM = ITEM_GOAL - 70;

	// expected child tours, worked out from every accepted parent position
	class child_tour_board;
		count_t      count_reg;
		city_t       parent_a[MAX_CITIES];
		city_t       seg_city[MAX_CITIES];
		city_t       map_to[MAX_CITIES];
		bit          mapped[MAX_CITIES];
		int unsigned load_pos;
		int unsigned seg_lo;
		int unsigned seg_hi;
		city_t       child_due[$];
		bit          last_due[$];
		int unsigned faults;

		function new();
			count_reg = count_t'(MAX_CITIES);
			load_pos  = 0;
			seg_lo    = 0;
			seg_hi    = 0;
			faults    = 0;
			for (int i = 0; i < MAX_CITIES; i++) begin
				parent_a[i] = '0;
				seg_city[i] = '0;
				map_to[i]   = '0;
				mapped[i]   = 1'b0;
			end
		endfunction

		function void set_count(count_t v);
			count_reg = v;
		endfunction

		// register value as the block uses it
		function int unsigned cities();
			int unsigned n;
			n = count_reg;
			if (n < 2)
				n = 2;
			if (n > MAX_CITIES)
				n = MAX_CITIES;
			return n;
		endfunction

		function int unsigned pending();
			return child_due.size();
		endfunction

		function void take_position(city_t a, city_t b, city_t cs, city_t ce);
			int unsigned n;
			int unsigned pos;
			int unsigned x;
			int unsigned y;
			int unsigned c;
			int unsigned hops;
			n   = cities();
			pos = load_pos % MAX_CITIES;
			// first position of a tour: latch, clamp and order the cut bounds, clear the map marks
			if (load_pos == 0) begin
				x = cs;
				y = ce;
				if (x > n - 1)
					x = n - 1;
				if (y > n - 1)
					y = n - 1;
				if (x > y) begin
					c = x;
					x = y;
					y = c;
				end
				seg_lo = x;
				seg_hi = y;
				for (int i = 0; i < MAX_CITIES; i++)
					mapped[i] = 1'b0;
			end
			parent_a[pos] = a;
			if (pos >= seg_lo && pos <= seg_hi) begin
				seg_city[pos] = b;
				map_to[b]     = a;
				mapped[b]     = 1'b1;
			end
			if (load_pos + 1 < n) begin
				load_pos++;
				return;
			end
			// whole tour in: build the child
			for (int i = 0; i < n; i++) begin
				if (i >= seg_lo && i <= seg_hi) begin
					c = seg_city[i];
				end else begin
					c    = parent_a[i];
					hops = 0;
					while (mapped[c] && hops < MAX_CITIES) begin
						c = map_to[c];
						hops++;
					end
				end
				child_due.push_back(city_t'(c));
				last_due.push_back(i == n - 1);
			end
			load_pos = 0;
		endfunction

		function void match_child(city_t c, logic last);
			city_t want_c;
			bit    want_l;
			if (child_due.size() == 0) begin
				$error("unexpected child transfer: child_city %0d last_child %0b", c, last);
				faults++;
				return;
			end
			want_c = child_due.pop_front();
			want_l = last_due.pop_front();
			if (c !== want_c) begin
				$error("child_city mismatch: expected %0d, actual %0d", want_c, c);
				faults++;
			end
			if (last !== want_l) begin
				$error("last_child mismatch: expected %0b, actual %0b", want_l, last);
				faults++;
			end
		endfunction
	endclass

	logic   clk;
	logic   arst_n             = 1'b0;
	logic   cfg_valid          = 1'b0;
	logic   cfg_ready;
	count_t cfg_city_count     = '0;
	logic   in_valid           = 1'b0;
	logic   in_stall;
	city_t  first_parent_city  = '0;
	city_t  second_parent_city = '0;
	city_t  cut_start          = '0;
	city_t  cut_end            = '0;
	logic   out_valid;
	logic   out_stall          = 1'b0;
	city_t  child_city;
	logic   last_child;

	child_tour_board board = new();

	city_t       tour_a[$];
	city_t       tour_b[$];
	city_t       pick_lo;
	city_t       pick_hi;
	int unsigned items_fed = 0;
	int unsigned hold_left = 0;
	bit          gaps_on   = 1'b0;
	bit          stalls_on = 1'b0;
	bit          calm      = 1'b0;

	partially_mapped_crossover_top DUT (
		.clk                (clk),
		.arst_n             (arst_n),
		.cfg_valid          (cfg_valid),
		.cfg_ready          (cfg_ready),
		.cfg_city_count     (cfg_city_count),
		.in_valid           (in_valid),
		.in_stall           (in_stall),
		.first_parent_city  (first_parent_city),
		.second_parent_city (second_parent_city),
		.cut_start          (cut_start),
		.cut_end            (cut_end),
		.out_valid          (out_valid),
		.out_stall          (out_stall),
		.child_city         (child_city),
		.last_child         (last_child)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// result side: check each transfer, then decide the stall for the next cycle
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			board.match_child(child_city, last_child);
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if (stalls_on && !calm && $urandom_range(0, 9) < 2) begin
			hold_left = $urandom_range(0, 3);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	task automatic write_count(count_t v);
		cfg_valid      <= 1'b1;
		cfg_city_count <= v;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		board.set_count(v);
	endtask

	// stop sending and let every outstanding child drain out
	task automatic drain();
		in_valid <= 1'b0;
		while (board.pending() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic push_position(city_t a, city_t b, city_t cs, city_t ce);
		if (gaps_on && !calm && $urandom_range(0, 9) < 2) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid           <= 1'b1;
		first_parent_city  <= a;
		second_parent_city <= b;
		cut_start          <= cs;
		cut_end            <= ce;
		do
			@(posedge clk);
		while (in_stall);
		board.take_position(a, b, cs, ce);
		items_fed++;
		calm = (items_fed >= CALM_FROM);
	endtask

	// one tour from tour_a/tour_b; cut fields past the first position are noise
	task automatic feed_tour(int unsigned n, city_t cs, city_t ce);
		for (int i = 0; i < n; i++) begin
			if (i == 0)
				push_position(tour_a[i], tour_b[i], cs, ce);
			else
				push_position(tour_a[i], tour_b[i], city_t'($urandom_range(0, 63)),
					city_t'($urandom_range(0, 63)));
		end
	endtask

	task automatic directed_tour(count_t cnt, city_t cs, city_t ce);
		drain();
		write_count(cnt);
		feed_tour(board.cities(), cs, ce);
	endtask

	// mostly two orderings of one city set, sometimes plain noise; also picks the cut bounds
	task automatic make_tour(int unsigned n);
		int unsigned j;
		city_t       t;
		city_t       pool[MAX_CITIES];
		for (int i = 0; i < MAX_CITIES; i++)
			pool[i] = city_t'(i);
		for (int i = MAX_CITIES - 1; i > 0; i--) begin
			j       = $urandom_range(0, i);
			t       = pool[i];
			pool[i] = pool[j];
			pool[j] = t;
		end
		tour_a.delete();
		tour_b.delete();
		for (int i = 0; i < n; i++)
			tour_a.push_back(pool[i]);
		for (int i = n - 1; i > 0; i--) begin
			j       = $urandom_range(0, i);
			t       = pool[i];
			pool[i] = pool[j];
			pool[j] = t;
		end
		for (int i = 0; i < n; i++)
			tour_b.push_back(pool[i]);
		if ($urandom_range(0, 99) < 15) begin
			for (int i = 0; i < n; i++) begin
				tour_a[i] = city_t'($urandom_range(0, 63));
				tour_b[i] = city_t'($urandom_range(0, 63));
			end
		end
		if ($urandom_range(0, 3) != 0) begin
			pick_lo = city_t'($urandom_range(0, n - 1));
			pick_hi = city_t'($urandom_range(0, n - 1));
		end else begin
			pick_lo = city_t'($urandom_range(0, 63));
			pick_hi = city_t'($urandom_range(0, 63));
		end
	endtask

	initial begin
		int unsigned phase;
		int unsigned tours;
		count_t      cnt;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: field extremes, bound handling, count clamping
		tour_a = '{0, 63};
		tour_b = '{63, 0};
		directed_tour(count_t'(2), city_t'(63), city_t'(0));   // reversed and past the count
		tour_a = '{5, 7};
		tour_b = '{7, 5};
		directed_tour(count_t'(2), city_t'(0), city_t'(0));    // single position segment
		tour_a = '{63, 0};
		tour_b = '{0, 63};
		directed_tour(count_t'(2), city_t'(1), city_t'(1));
		tour_a = '{9, 4};
		tour_b = '{4, 9};
		directed_tour(count_t'(0), city_t'(1), city_t'(0));    // count below two
		tour_a = '{3, 3};
		tour_b = '{3, 3};
		directed_tour(count_t'(1), city_t'(63), city_t'(63));
		// mapping loop: the chase has to give up after the hop limit
		tour_a = '{1, 2, 3, 1, 2};
		tour_b = '{2, 3, 1, 4, 5};
		directed_tour(count_t'(5), city_t'(0), city_t'(2));
		// repeated city in the segment: later mapping wins
		tour_a = '{10, 11, 12, 13, 20};
		tour_b = '{20, 20, 21, 40, 41};
		directed_tour(count_t'(5), city_t'(2), city_t'(0));

		// random phases, a fresh count per phase
		phase = 0;
		while (items_fed < ITEM_GOAL) begin
			case (phase)
				0: cnt = count_t'(127);
				1: cnt = count_t'(1);
				2: cnt = count_t'(MAX_CITIES);
				default: begin
					if ($urandom_range(0, 9) == 0)
						cnt = count_t'($urandom_range(0, 1));
					else
						cnt = count_t'($urandom_range(2, 16));
				end
			endcase
			drain();
			write_count(cnt);
			gaps_on   = ($urandom_range(0, 3) != 0);
			stalls_on = ($urandom_range(0, 3) != 0);
			tours     = (board.cities() >= 32) ? 1 : $urandom_range(1, 4);
			repeat (tours) begin
				make_tour(board.cities());
				feed_tour(board.cities(), pick_lo, pick_hi);
			end
			phase++;
		end

		drain();
		repeat (12) @(posedge clk);
		if (board.faults == 0 && board.pending() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	// watchdog
	initial begin
		#5_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
